FILE: sv/psvp_pkg.sv
// psvp_pkg: shared types and constants for the planar shadow vertex projector.
// No dependencies; used by psvp_setup and planar_shadow_vertex_projector.
package psvp_pkg;

  // Direction vectors are Q2.14
  localparam int DIR_FRAC   = 14;
  localparam int DIR_W      = 16;
  localparam int COORD_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = 3'd6;

  // Register reset values
  localparam logic signed [DIR_W-1:0] DIR_ONE = 16'sd16384;

  // Saturation limits of a coordinate
  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic                      end_of_mesh;
  } psvp_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] shadow_x;
    logic signed [COORD_W-1:0] shadow_y;
    logic signed [COORD_W-1:0] shadow_z;
    logic                      last_vertex;
  } psvp_out_t;

  // Plane normal and light direction handed to the setup unit
  typedef struct packed {
    logic signed [DIR_W-1:0] normal_x;
    logic signed [DIR_W-1:0] normal_y;
    logic signed [DIR_W-1:0] normal_z;
    logic signed [DIR_W-1:0] light_dir_x;
    logic signed [DIR_W-1:0] light_dir_y;
    logic signed [DIR_W-1:0] light_dir_z;
  } psvp_dir_t;

  // Status and result of the setup unit
  typedef struct packed {
    logic                      busy;
    logic signed [COORD_W-1:0] scaled_x;
    logic signed [COORD_W-1:0] scaled_y;
    logic signed [COORD_W-1:0] scaled_z;
  } psvp_setup_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DOT,
    ST_CHECK,
    ST_CORR,
    ST_DIVSET,
    ST_DIV,
    ST_DIVEND,
    ST_IDLE
  } psvp_state_e;

endpackage

FILE: sv/planar_shadow_vertex_projector.sv
// planar_shadow_vertex_projector: projects vertices onto a ground plane along a light direction.
// Items pass through registered stages 1 to 5 (stage 5 drives out_valid_o), one item per cycle
// unless out_stall_i or setup holds the pipe. After reset and after every config write a setup
// pass, bounded by the bit-serial divider, holds in_stall_o high; config writes are still taken.
// Reset (rst_ni, async, active low) empties the pipe and restores the register defaults.
// Depends on psvp_pkg and psvp_setup.
module planar_shadow_vertex_projector #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [psvp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psvp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // vertex input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  psvp_pkg::psvp_in_t                in_data_i,
  // shadow output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output psvp_pkg::psvp_out_t               out_data_o
);

  localparam int CW    = psvp_pkg::COORD_W;
  localparam int DW    = psvp_pkg::DIR_W;
  localparam int P_W   = CW + DW;                   // vertex * normal
  localparam int HW_W  = P_W + 2;                   // V.N + offset, Q.30
  localparam int H_W   = HW_W - psvp_pkg::DIR_FRAC; // height h, coordinate format
  localparam int HH_W  = H_W - COORD_FRAC_BITS;     // integer part of h
  localparam int PH_W  = HH_W + CW;                 // hh * S
  localparam int PL_W  = COORD_FRAC_BITS + 1 + CW;  // hl * S
  localparam int PR_W  = PH_W + 1;                  // h * S rounded
  localparam int DF_W  = PR_W + 1;                  // V - h * S

  localparam logic signed [HW_W-1:0] HW_RND = HW_W'(1) << (psvp_pkg::DIR_FRAC - 1);
  localparam logic signed [PL_W-1:0] PL_RND = PL_W'(1) << (COORD_FRAC_BITS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] normal_q [3];
  logic signed [DW-1:0] light_q  [3];
  logic signed [CW-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= psvp_pkg::DIR_ONE;
      light_q[0]  <= '0;
      light_q[1]  <= '0;
      light_q[2]  <= psvp_pkg::DIR_ONE;
      offset_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psvp_pkg::CFG_NORMAL_X:     normal_q[0] <= cfg_wdata_i[DW-1:0];
        psvp_pkg::CFG_NORMAL_Y:     normal_q[1] <= cfg_wdata_i[DW-1:0];
        psvp_pkg::CFG_NORMAL_Z:     normal_q[2] <= cfg_wdata_i[DW-1:0];
        psvp_pkg::CFG_LIGHT_DIR_X:  light_q[0]  <= cfg_wdata_i[DW-1:0];
        psvp_pkg::CFG_LIGHT_DIR_Y:  light_q[1]  <= cfg_wdata_i[DW-1:0];
        psvp_pkg::CFG_LIGHT_DIR_Z:  light_q[2]  <= cfg_wdata_i[DW-1:0];
        psvp_pkg::CFG_PLANE_OFFSET: offset_q    <= cfg_wdata_i[CW-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Setup: scaled light S, recomputed after reset and every config write.
  // Any write restarts it, so a burst of writes ends with one clean pass.
  // ---------------------------------------------------------------------------
  psvp_pkg::psvp_dir_t   dir_cfg;
  psvp_pkg::psvp_setup_t setup_stat;
  logic signed [CW-1:0]  sl [3];

  assign dir_cfg.normal_x    = normal_q[0];
  assign dir_cfg.normal_y    = normal_q[1];
  assign dir_cfg.normal_z    = normal_q[2];
  assign dir_cfg.light_dir_x = light_q[0];
  assign dir_cfg.light_dir_y = light_q[1];
  assign dir_cfg.light_dir_z = light_q[2];

  psvp_setup #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .dir_i     (dir_cfg),
    .stat_o    (setup_stat)
  );

  assign sl[0] = setup_stat.scaled_x;
  assign sl[1] = setup_stat.scaled_y;
  assign sl[2] = setup_stat.scaled_z;

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves when it is empty or its successor moves, so
  // bubbles close up while the output register waits on out_stall_i.
  // ---------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_acc;

  assign rdy5   = !s5_vld_q || !out_stall_i;
  assign rdy4   = !s4_vld_q || rdy5;
  assign rdy3   = !s3_vld_q || rdy4;
  assign rdy2   = !s2_vld_q || rdy3;
  assign rdy1   = !s1_vld_q || rdy2;
  assign in_stall_o = setup_stat.busy || !rdy1;
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      if (rdy1) s1_vld_q <= in_acc;
      if (rdy2) s2_vld_q <= s1_vld_q;
      if (rdy3) s3_vld_q <= s2_vld_q;
      if (rdy4) s4_vld_q <= s3_vld_q;
      if (rdy5) s5_vld_q <= s4_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: vertex times normal, one 32x16 product per lane
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]  v_in [3];
  logic signed [CW-1:0]  s1_v_q [3];
  logic signed [P_W-1:0] s1_p_q [3];
  logic                  s1_eom_q;

  assign v_in[0] = in_data_i.vertex_x;
  assign v_in[1] = in_data_i.vertex_y;
  assign v_in[2] = in_data_i.vertex_z;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        s1_v_q[i] <= v_in[i];
        s1_p_q[i] <= P_W'(v_in[i]) * P_W'(normal_q[i]);
      end
      s1_eom_q <= in_data_i.end_of_mesh;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: h = round(V.N + offset*2^14) / 2^14, floor after half-up bias
  // ---------------------------------------------------------------------------
  logic signed [HW_W-1:0] hw;
  logic signed [H_W-1:0]  s2_h_q;
  logic signed [CW-1:0]   s2_v_q [3];
  logic                   s2_eom_q;

  assign hw = HW_W'(s1_p_q[0]) + HW_W'(s1_p_q[1]) + HW_W'(s1_p_q[2])
            + (HW_W'(offset_q) <<< psvp_pkg::DIR_FRAC) + HW_RND;

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_vld_q) begin
      s2_h_q   <= H_W'(hw >>> psvp_pkg::DIR_FRAC);
      s2_v_q   <= s1_v_q;
      s2_eom_q <= s1_eom_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: h split into integer and fraction parts, each times S
  // ---------------------------------------------------------------------------
  logic signed [HH_W-1:0]              hh;
  logic signed [COORD_FRAC_BITS:0]     hl;
  logic signed [PH_W-1:0]              s3_ph_q [3];
  logic signed [PL_W-1:0]              s3_pl_q [3];
  logic signed [CW-1:0]                s3_v_q [3];
  logic                                s3_eom_q;

  assign hh = HH_W'(s2_h_q >>> COORD_FRAC_BITS);
  assign hl = $signed({1'b0, s2_h_q[COORD_FRAC_BITS-1:0]});

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        s3_ph_q[i] <= PH_W'(hh) * PH_W'(sl[i]);
        s3_pl_q[i] <= PL_W'(hl) * PL_W'(sl[i]);
      end
      s3_v_q   <= s2_v_q;
      s3_eom_q <= s2_eom_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: h*S in coordinate format, fraction product rounded half up
  // ---------------------------------------------------------------------------
  logic signed [PR_W-1:0] s4_prod_q [3];
  logic signed [CW-1:0]   s4_v_q [3];
  logic                   s4_eom_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        s4_prod_q[i] <= PR_W'(s3_ph_q[i])
                      + PR_W'((s3_pl_q[i] + PL_RND) >>> COORD_FRAC_BITS);
      end
      s4_v_q   <= s3_v_q;
      s4_eom_q <= s3_eom_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5 (output register): V - h*S, saturated to 32 bits
  // ---------------------------------------------------------------------------
  logic signed [DF_W-1:0] diff [3];
  logic signed [CW-1:0]   shadow_d [3];
  psvp_pkg::psvp_out_t    out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DF_W'(s4_v_q[i]) - DF_W'(s4_prod_q[i]);
      if (diff[i] > DF_W'(psvp_pkg::SAT_MAX)) begin
        shadow_d[i] = psvp_pkg::SAT_MAX;
      end else if (diff[i] < DF_W'(psvp_pkg::SAT_MIN)) begin
        shadow_d[i] = psvp_pkg::SAT_MIN;
      end else begin
        shadow_d[i] = CW'(diff[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && s4_vld_q) begin
      out_q.shadow_x    <= shadow_d[0];
      out_q.shadow_y    <= shadow_d[1];
      out_q.shadow_z    <= shadow_d[2];
      out_q.last_vertex <= s4_eom_q;
    end
  end

  assign out_valid_o = s5_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/psvp_setup.sv
// psvp_setup: computes the scaled light vector S = L / (L.N) after reset or a config write.
// Shared 21x16 multiplier for dot products and correction, bit-serial restoring divider.
// Depends on psvp_pkg.
module psvp_setup #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  psvp_pkg::psvp_dir_t   dir_i,
  output psvp_pkg::psvp_setup_t stat_o
);

  localparam int L_W   = 21;                      // corrected light component
  localparam int K_W   = 19;                      // correction factor, Q14
  localparam int MP_W  = L_W + psvp_pkg::DIR_W;   // shared multiplier product
  localparam int ACC_W = 38;                      // d in Q10.28
  localparam int NUM_W = L_W + COORD_FRAC_BITS + psvp_pkg::DIR_FRAC;
  localparam int QS_W  = NUM_W + 1;
  localparam int R_W   = ACC_W + 1;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic signed [ACC_W-1:0] D_HALF =
      ACC_W'(1) << (2 * psvp_pkg::DIR_FRAC - 1);
  localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << (psvp_pkg::DIR_FRAC - 1);
  localparam logic signed [MP_W-1:0]  MP_RND  = MP_W'(1) << (psvp_pkg::DIR_FRAC - 1);
  localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(NUM_W - 1);
  localparam logic [1:0]              IDX_LAST = 2'd2;

  psvp_pkg::psvp_state_e state_q, state_d;

  logic signed [psvp_pkg::DIR_W-1:0]   n [3];
  logic signed [L_W-1:0]               l_q [3];
  logic signed [psvp_pkg::COORD_W-1:0] sl_q [3];
  logic signed [ACC_W-1:0]             acc_q;
  logic signed [K_W-1:0]               k_q;
  logic [1:0]                          idx_q;
  logic                                pass_q;
  logic [NUM_W-1:0]                    num_q;
  logic [NUM_W-1:0]                    quo_q;
  logic [R_W-1:0]                      rem_q;
  logic [CNT_W-1:0]                    cnt_q;
  logic                                neg_q;

  logic signed [L_W-1:0]               mul_a;
  logic signed [psvp_pkg::DIR_W-1:0]   mul_b;
  logic signed [MP_W-1:0]              mp;
  logic [R_W-1:0]                      d_mag;
  logic [R_W-1:0]                      r2;
  logic signed [L_W-1:0]               l_sel;
  logic [L_W-1:0]                      l_abs;
  logic signed [QS_W-1:0]              sq;
  logic signed [psvp_pkg::COORD_W-1:0] sq_sat;

  assign n[0] = dir_i.normal_x;
  assign n[1] = dir_i.normal_y;
  assign n[2] = dir_i.normal_z;

  // Next state
  always_comb begin
    state_d = state_q;
    if (restart_i) begin
      state_d = psvp_pkg::ST_LOAD;
    end else begin
      unique case (state_q)
        psvp_pkg::ST_LOAD:   state_d = psvp_pkg::ST_DOT;
        psvp_pkg::ST_DOT: begin
          if (idx_q == IDX_LAST) begin
            state_d = pass_q ? psvp_pkg::ST_DIVSET : psvp_pkg::ST_CHECK;
          end
        end
        psvp_pkg::ST_CHECK: begin
          state_d = (acc_q < D_HALF) ? psvp_pkg::ST_CORR : psvp_pkg::ST_DIVSET;
        end
        psvp_pkg::ST_CORR: begin
          if (idx_q == IDX_LAST) state_d = psvp_pkg::ST_DOT;
        end
        psvp_pkg::ST_DIVSET: begin
          state_d = (acc_q <= ACC_ZERO) ? psvp_pkg::ST_IDLE : psvp_pkg::ST_DIV;
        end
        psvp_pkg::ST_DIV: begin
          if (cnt_q == CNT_LAST) state_d = psvp_pkg::ST_DIVEND;
        end
        psvp_pkg::ST_DIVEND: begin
          state_d = (idx_q == IDX_LAST) ? psvp_pkg::ST_IDLE : psvp_pkg::ST_DIVSET;
        end
        psvp_pkg::ST_IDLE:   state_d = psvp_pkg::ST_IDLE;
        default:             state_d = psvp_pkg::ST_LOAD;
      endcase
    end
  end

  // Outputs and multiplier operand select
  always_comb begin
    stat_o.busy     = (state_q != psvp_pkg::ST_IDLE) || restart_i;
    stat_o.scaled_x = sl_q[0];
    stat_o.scaled_y = sl_q[1];
    stat_o.scaled_z = sl_q[2];
    mul_a = (state_q == psvp_pkg::ST_CORR) ? L_W'(k_q) : l_q[idx_q];
    mul_b = n[idx_q];
  end

  assign mp = MP_W'(mul_a) * MP_W'(mul_b);

  // Divider datapath
  assign d_mag  = R_W'($unsigned(acc_q));
  assign r2     = {rem_q[R_W-2:0], num_q[NUM_W-1]};
  assign l_sel  = l_q[idx_q];
  assign l_abs  = $unsigned((l_sel < 0) ? -l_sel : l_sel);
  assign sq     = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_comb begin
    if (sq > QS_W'(psvp_pkg::SAT_MAX)) begin
      sq_sat = psvp_pkg::SAT_MAX;
    end else if (sq < QS_W'(psvp_pkg::SAT_MIN)) begin
      sq_sat = psvp_pkg::SAT_MIN;
    end else begin
      sq_sat = psvp_pkg::COORD_W'(sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psvp_pkg::ST_LOAD;
      idx_q   <= '0;
      pass_q  <= 1'b0;
      cnt_q   <= '0;
      for (int i = 0; i < 3; i++) sl_q[i] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        psvp_pkg::ST_LOAD: begin
          idx_q  <= '0;
          pass_q <= 1'b0;
        end
        psvp_pkg::ST_DOT,
        psvp_pkg::ST_CORR: begin
          idx_q <= (idx_q == IDX_LAST) ? 2'd0 : idx_q + 2'd1;
          if (state_q == psvp_pkg::ST_CORR && idx_q == IDX_LAST) pass_q <= 1'b1;
        end
        psvp_pkg::ST_CHECK: idx_q <= '0;
        psvp_pkg::ST_DIVSET: begin
          cnt_q <= '0;
          if (acc_q <= ACC_ZERO) begin
            for (int i = 0; i < 3; i++) sl_q[i] <= '0;
          end
        end
        psvp_pkg::ST_DIV:    cnt_q <= cnt_q + CNT_W'(1);
        psvp_pkg::ST_DIVEND: begin
          sl_q[idx_q] <= sq_sat;
          idx_q       <= (idx_q == IDX_LAST) ? 2'd0 : idx_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      psvp_pkg::ST_LOAD: begin
        l_q[0] <= L_W'(dir_i.light_dir_x);
        l_q[1] <= L_W'(dir_i.light_dir_y);
        l_q[2] <= L_W'(dir_i.light_dir_z);
        acc_q  <= '0;
      end
      psvp_pkg::ST_DOT: acc_q <= acc_q + ACC_W'(mp);
      psvp_pkg::ST_CHECK: begin
        k_q <= K_W'((D_HALF - acc_q + ACC_RND) >>> psvp_pkg::DIR_FRAC);
      end
      psvp_pkg::ST_CORR: begin
        l_q[idx_q] <= l_q[idx_q] + L_W'((mp + MP_RND) >>> psvp_pkg::DIR_FRAC);
        if (idx_q == IDX_LAST) acc_q <= '0;
      end
      psvp_pkg::ST_DIVSET: begin
        num_q <= NUM_W'(l_abs) << (COORD_FRAC_BITS + psvp_pkg::DIR_FRAC);
        neg_q <= (l_sel < 0);
        rem_q <= '0;
        quo_q <= '0;
      end
      psvp_pkg::ST_DIV: begin
        num_q <= num_q << 1;
        if (r2 >= d_mag) begin
          rem_q <= r2 - d_mag;
          quo_q <= {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= r2;
          quo_q <= {quo_q[NUM_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for planar_shadow_vertex_projector.
// Drives vertex items and register writes, predicts each shadow item in SystemVerilog.
// Depends on psvp_pkg and the projector RTL only.
module tb_top;

  localparam int COORD_FRAC = 16;
  localparam int PIPE_LATENCY = 5;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_OFF_CYCLES = 300;
  // Index past the last register; the block must ignore it
  localparam logic [psvp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Fixed-point helpers
  localparam longint D_HALF = longint'(1) << 27;           // one half in Q4.28
  localparam longint DIR_RND = longint'(1) << (psvp_pkg::DIR_FRAC - 1);
  localparam longint COORD_RND = longint'(1) << (COORD_FRAC - 1);
  localparam longint COORD_ONE = longint'(1) << COORD_FRAC;
  localparam longint DIR_ONE_L = longint'(1) << psvp_pkg::DIR_FRAC;
  localparam longint DIV_SCALE = longint'(1) << (COORD_FRAC + psvp_pkg::DIR_FRAC);

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [psvp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [psvp_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  psvp_pkg::psvp_in_t              in_data_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  psvp_pkg::psvp_out_t             out_data_o;

  planar_shadow_vertex_projector #(
    .COORD_FRAC_BITS(COORD_FRAC)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers and the derived light vector.
  // ---------------------------------------------------------------------------
  logic signed [psvp_pkg::DIR_W-1:0]   plane_normal [3];
  logic signed [psvp_pkg::DIR_W-1:0]   light_dir [3];
  logic signed [psvp_pkg::COORD_W-1:0] plane_offset;
  longint                              scaled_light [3];
  bit                                  light_ready;     // cleared by every register write

  psvp_pkg::psvp_out_t shadow_expect_q [$];    // expected shadow items, oldest first
  psvp_pkg::psvp_out_t shadow_got;
  psvp_pkg::psvp_out_t shadow_want;

  int errors;
  bit tx_idle_on;          // sender inserts random gaps
  bit rx_idle_on;          // receiver inserts random stalls
  int rx_stall_left;       // stall cycles still owed for the current item
  int rx_hold_cycles;      // long hold-off, counted down by the receiver process

  // ---------------------------------------------------------------------------
  // Clock, reset, time limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The worst legal run ends well inside this time limit.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Reference arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic signed [psvp_pkg::COORD_W-1:0] clamp32(input longint x);
    if (x > longint'(psvp_pkg::SAT_MAX)) return psvp_pkg::SAT_MAX;
    if (x < longint'(psvp_pkg::SAT_MIN)) return psvp_pkg::SAT_MIN;
    return x[psvp_pkg::COORD_W-1:0];
  endfunction

  // Once per configuration: d = L.N in Q4.28; if the light grazes the plane
  // (d below one half) tilt L toward N and redo d. Then S = L / d.
  function automatic void derive_scaled_light();
    longint n [3];
    longint l [3];
    longint d;
    longint k;
    for (int i = 0; i < 3; i++) begin
      n[i] = plane_normal[i];
      l[i] = light_dir[i];
    end
    d = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
    if (d < D_HALF) begin
      k = (D_HALF - d + DIR_RND) >>> psvp_pkg::DIR_FRAC;
      for (int i = 0; i < 3; i++) l[i] += (k * n[i] + DIR_RND) >>> psvp_pkg::DIR_FRAC;
      d = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
    end
    for (int i = 0; i < 3; i++) begin
      // Light still at or below the plane: vertices pass through untouched
      if (d <= 0) scaled_light[i] = 0;
      else scaled_light[i] = clamp32((l[i] * DIV_SCALE) / d);
    end
    light_ready = 1'b1;
  endfunction

  // Shadow = V - h * S with h = V.N + offset, all rounding half up.
  function automatic psvp_pkg::psvp_out_t project_vertex(input psvp_pkg::psvp_in_t item);
    psvp_pkg::psvp_out_t res;
    longint v [3];
    longint n [3];
    longint c [3];
    longint hw;
    longint h;
    longint hh;
    longint hl;
    longint prod;
    if (!light_ready) derive_scaled_light();
    v[0] = $signed(item.vertex_x);
    v[1] = $signed(item.vertex_y);
    v[2] = $signed(item.vertex_z);
    for (int i = 0; i < 3; i++) n[i] = plane_normal[i];
    hw = v[0] * n[0] + v[1] * n[1] + v[2] * n[2] + longint'(plane_offset) * DIR_ONE_L;
    h = (hw + DIR_RND) >>> psvp_pkg::DIR_FRAC;
    // Split h so that h * S stays inside 64 bits
    hh = h >>> COORD_FRAC;
    hl = h - hh * COORD_ONE;
    for (int i = 0; i < 3; i++) begin
      prod = hh * scaled_light[i] + ((hl * scaled_light[i] + COORD_RND) >>> COORD_FRAC);
      c[i] = v[i] - prod;
    end
    res.shadow_x = clamp32(c[0]);
    res.shadow_y = clamp32(c[1]);
    res.shadow_z = clamp32(c[2]);
    res.last_vertex = item.end_of_mesh;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall driver and result checker
  // ---------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name,
                                      input logic signed [psvp_pkg::COORD_W-1:0] want,
                                      input logic signed [psvp_pkg::COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      shadow_got = out_data_o;
      if (shadow_expect_q.size() == 0) begin
        $error("unexpected shadow item: x %0d y %0d z %0d", shadow_got.shadow_x,
               shadow_got.shadow_y, shadow_got.shadow_z);
        errors++;
      end else begin
        shadow_want = shadow_expect_q.pop_front();
        check_field("shadow_x", shadow_want.shadow_x, shadow_got.shadow_x);
        check_field("shadow_y", shadow_want.shadow_y, shadow_got.shadow_y);
        check_field("shadow_z", shadow_want.shadow_z, shadow_got.shadow_z);
        check_field("last_vertex", psvp_pkg::COORD_W'(shadow_want.last_vertex),
                    psvp_pkg::COORD_W'(shadow_got.last_vertex));
      end
      rx_stall_left = rx_idle_on ? $urandom_range(0, 16) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offers one vertex item after a random gap and returns at the accepting edge.
  // Valid stays high on return so a back-to-back item needs no bubble.
  task automatic send_vertex(input psvp_pkg::psvp_in_t item);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    shadow_expect_q.push_back(project_vertex(item));
  endtask

  // Drop valid and wait until every expected shadow item has come back.
  task automatic wait_for_shadows();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // One register write; the predictor copy is updated at the write edge.
  task automatic write_reg(input logic [psvp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psvp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      psvp_pkg::CFG_NORMAL_X:     plane_normal[0] = data[psvp_pkg::DIR_W-1:0];
      psvp_pkg::CFG_NORMAL_Y:     plane_normal[1] = data[psvp_pkg::DIR_W-1:0];
      psvp_pkg::CFG_NORMAL_Z:     plane_normal[2] = data[psvp_pkg::DIR_W-1:0];
      psvp_pkg::CFG_LIGHT_DIR_X:  light_dir[0] = data[psvp_pkg::DIR_W-1:0];
      psvp_pkg::CFG_LIGHT_DIR_Y:  light_dir[1] = data[psvp_pkg::DIR_W-1:0];
      psvp_pkg::CFG_LIGHT_DIR_Z:  light_dir[2] = data[psvp_pkg::DIR_W-1:0];
      psvp_pkg::CFG_PLANE_OFFSET: plane_offset = data;
      default: ;
    endcase
    if (idx <= psvp_pkg::CFG_PLANE_OFFSET) light_ready = 1'b0;
  endtask

  // Waits for idle, then writes all seven registers. Junk in the upper half
  // of a 16-bit register write must be dropped by the block.
  task automatic program_plane(input logic signed [psvp_pkg::DIR_W-1:0] nx, ny, nz,
                               input logic signed [psvp_pkg::DIR_W-1:0] lx, ly, lz,
                               input logic signed [psvp_pkg::COORD_W-1:0] off);
    wait_for_shadows();
    write_reg(psvp_pkg::CFG_NORMAL_X, {16'($urandom), nx});
    write_reg(psvp_pkg::CFG_NORMAL_Y, {16'($urandom), ny});
    write_reg(psvp_pkg::CFG_NORMAL_Z, {16'($urandom), nz});
    write_reg(psvp_pkg::CFG_LIGHT_DIR_X, {16'($urandom), lx});
    write_reg(psvp_pkg::CFG_LIGHT_DIR_Y, {16'($urandom), ly});
    write_reg(psvp_pkg::CFG_LIGHT_DIR_Z, {16'($urandom), lz});
    write_reg(psvp_pkg::CFG_PLANE_OFFSET, off);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic psvp_pkg::psvp_in_t make_vertex(
      input logic signed [psvp_pkg::COORD_W-1:0] x, y, z,
      input logic eom);
    psvp_pkg::psvp_in_t item;
    item.vertex_x = x;
    item.vertex_y = y;
    item.vertex_z = z;
    item.end_of_mesh = eom;
    return item;
  endfunction

  // Mostly in-range Q2.14, sometimes the range ends, sometimes any bit pattern
  function automatic logic signed [psvp_pkg::DIR_W-1:0] pick_dir_component();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? psvp_pkg::DIR_ONE : -psvp_pkg::DIR_ONE;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Mix of corner values, full-range noise and modest coordinates (+-128.0)
  function automatic logic signed [psvp_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return psvp_pkg::SAT_MIN;
          1: return psvp_pkg::SAT_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset setup: N = L = +z, so S = (0, 0, 1.0) and every z collapses to 0.
  task automatic test_reset_defaults();
    send_vertex(make_vertex('0, '0, '0, 1'b0));
    send_vertex(make_vertex(psvp_pkg::SAT_MAX, psvp_pkg::SAT_MAX, psvp_pkg::SAT_MAX, 1'b0));
    send_vertex(make_vertex(psvp_pkg::SAT_MIN, psvp_pkg::SAT_MIN, psvp_pkg::SAT_MIN, 1'b0));
    send_vertex(make_vertex(psvp_pkg::SAT_MAX, psvp_pkg::SAT_MIN, 32'sh0003_8000, 1'b0));
    send_vertex(make_vertex('1, 32'sh0001_0000, 32'shFFFE_0000, 1'b1));
  endtask

  task automatic test_special_planes();
    // Grazing light: L.N under one half, tilted toward the normal
    program_plane('0, '0, psvp_pkg::DIR_ONE, psvp_pkg::DIR_ONE, '0, 16'sd1000, '0);
    send_vertex(make_vertex('0, '0, 32'sh000A_0000, 1'b0));
    send_vertex(make_vertex(32'sh0005_0000, 32'shFFFD_0000, 32'sh0001_0000, 1'b0));
    send_vertex(make_vertex(psvp_pkg::SAT_MAX, psvp_pkg::SAT_MIN, psvp_pkg::SAT_MAX, 1'b1));
    // Zero normal: light never gets above the plane, vertices pass through
    program_plane('0, '0, '0, -psvp_pkg::DIR_ONE, psvp_pkg::DIR_ONE, -psvp_pkg::DIR_ONE,
                  psvp_pkg::SAT_MAX);
    send_vertex(make_vertex(32'sh1234_5678, 32'shEDCB_A988, psvp_pkg::SAT_MIN, 1'b0));
    send_vertex(make_vertex(psvp_pkg::SAT_MAX, '0, '1, 1'b1));
    // Bit patterns past the Q2.14 range and the lowest offset; saturates
    program_plane(16'sh8000, 16'sh7FFF, -psvp_pkg::DIR_ONE, psvp_pkg::DIR_ONE,
                  -psvp_pkg::DIR_ONE, 16'sh8000, psvp_pkg::SAT_MIN);
    send_vertex(make_vertex(psvp_pkg::SAT_MAX, psvp_pkg::SAT_MAX, psvp_pkg::SAT_MIN, 1'b0));
    send_vertex(make_vertex(32'sh0000_8000, '1, 32'sh0002_0000, 1'b1));
    // Light from below the plane: the correction flips it above
    program_plane('0, '0, psvp_pkg::DIR_ONE, '0, '0, -psvp_pkg::DIR_ONE, 32'sh0001_0000);
    send_vertex(make_vertex(32'sh0004_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0));
    send_vertex(make_vertex(psvp_pkg::SAT_MIN, psvp_pkg::SAT_MAX, psvp_pkg::SAT_MAX, 1'b1));
    // Write past the last register: nothing changes
    wait_for_shadows();
    write_reg(CFG_UNUSED, $urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    send_vertex(make_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back-to-back items, so the pipe fills and in_stall_o must rise.
  task automatic test_output_backpressure();
    program_plane(pick_dir_component(), pick_dir_component(), psvp_pkg::DIR_ONE,
                  pick_dir_component(), pick_dir_component(), psvp_pkg::DIR_ONE, $urandom);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    @(posedge clk_i);
    rx_hold_cycles = HOLD_OFF_CYCLES;
    for (int j = 0; j < 40; j++) begin
      send_vertex(make_vertex(pick_coord(), pick_coord(), pick_coord(), j == 39));
    end
    wait_for_shadows();
  endtask

  // Random planes, each followed by a random mesh; idling toggles per mesh.
  task automatic test_random_meshes();
    int sent;
    int mesh_len;
    logic signed [psvp_pkg::COORD_W-1:0] off;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      off = ($urandom_range(0, 3) == 0) ? $urandom :
            $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      program_plane(pick_dir_component(), pick_dir_component(), pick_dir_component(),
                    pick_dir_component(), pick_dir_component(), pick_dir_component(), off);
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      mesh_len = $urandom_range(10, 60);
      for (int j = 0; j < mesh_len; j++) begin
        send_vertex(make_vertex(pick_coord(), pick_coord(), pick_coord(),
                                (j == mesh_len - 1) || ($urandom_range(0, 15) == 0)));
        // Now and then the sender stops until the pipe has drained
        if ($urandom_range(0, 99) == 0) wait_for_shadows();
      end
      sent += mesh_len;
    end
    wait_for_shadows();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    errors = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_stall_left = 0;
    rx_hold_cycles = 0;
    plane_normal = '{16'sd0, 16'sd0, psvp_pkg::DIR_ONE};
    light_dir = '{16'sd0, 16'sd0, psvp_pkg::DIR_ONE};
    plane_offset = '0;
    scaled_light = '{0, 0, 0};
    light_ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_special_planes();
    test_output_backpressure();
    test_random_meshes();

    // Let a stray late item show up before the verdict
    repeat (PIPE_LATENCY * 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/psvp_pkg.sv
sv/psvp_setup.sv
sv/planar_shadow_vertex_projector.sv
sim/tb_top.sv
